// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL module that includes them.
// Expects clk and rst_n in scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/aesfr_pkg.sv -----
// Package for the AES forward round block: S-box table and GF(2^8) helpers.
// No dependencies.
`timescale 1ns / 1ps

package aesfr_pkg;

  localparam int unsigned BYTES = 16;
  localparam int unsigned HALF_W = 64;

  typedef logic [7:0] byte_t;
  typedef byte_t state_t [BYTES];

  localparam byte_t SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // multiply by 02 modulo x^8+x^4+x^3+x+1
  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // one MixColumns column, a0 in the top byte
  function automatic logic [31:0] mix_col(input logic [31:0] col);
    byte_t a0, a1, a2, a3, d0, d1, d2, d3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    d0 = xtime(a0);
    d1 = xtime(a1);
    d2 = xtime(a2);
    d3 = xtime(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

endpackage

// ----- src/aes_forward_round_no_key.sv -----
// AES forward round without key addition: SubBytes, ShiftRows and, unless final round, MixColumns.
// Depends on aesfr_pkg and assert_macros.svh.
//
// Channel  | Ports                                        | Handshake
// input    | in_state_hi, in_state_lo, in_final_round     | start && !busy
// result   | out_hi, out_lo                               | out_valid, one cycle
//
// The input register feeds S-box, ShiftRows and MixColumns
// into the result register. One beat is taken every cycle; busy stays low.
// Synchronous active-low reset clears the valid flags only.
// The result beat is held for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aes_forward_round_no_key (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [aesfr_pkg::HALF_W-1:0]     in_state_hi,
  input  logic [aesfr_pkg::HALF_W-1:0]     in_state_lo,
  input  logic                             in_final_round,
  output logic                             out_valid,
  output logic [aesfr_pkg::HALF_W-1:0]     out_hi,
  output logic [aesfr_pkg::HALF_W-1:0]     out_lo
);
  import aesfr_pkg::*;

  logic                  in_valid_r;
  logic [2*HALF_W-1:0]   in_state_r;
  logic                  in_final_r;
  logic                  out_valid_r;
  logic [2*HALF_W-1:0]   out_state_r;
  logic [2*HALF_W-1:0]   out_state_nxt;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_state_r <= {in_state_hi, in_state_lo};
      in_final_r <= in_final_round;
    end
    if (in_valid_r) begin
      out_state_r <= out_state_nxt;
    end
  end

  // byte b sits at bits 127-8b; row b%4, column b/4
  always_comb begin
    state_t s;
    state_t t;
    logic [31:0] col;
    for (int b = 0; b < BYTES; b++) begin
      s[b] = in_state_r[2*HALF_W-1-8*b -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      col = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      if (!in_final_r) begin
        col = mix_col(col);
      end
      out_state_nxt[2*HALF_W-1-32*c -: 32] = col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hi    = out_state_r[2*HALF_W-1:HALF_W];
  assign out_lo    = out_state_r[HALF_W-1:0];

  `ASSERT_NEXT(a_accept_loads, start && !busy, in_valid_r)
  `ASSERT_NEXT(a_idle_empty, !start, !in_valid_r)
  `ASSERT_NEXT(a_valid_advance, in_valid_r, out_valid)
  `ASSERT_NEXT(a_no_phantom, !in_valid_r, !out_valid)
  `ASSERT_SAME(a_never_busy, 1'b1, !busy)

endmodule
